// File: rtl/core/spc_pkg.sv
// shared constants, types and state codes for the stack pop sequence checker
`default_nettype none

package spc_pkg;

    localparam int STACK_DEPTH = 1024;

    localparam int VALUE_W = 10;
    localparam int CAP_W = 11;
    localparam int LEN_W = 10;
    localparam int NPUSH_W = LEN_W + 1;
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CMP_W = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_STACK_CAPACITY = 1'b0;
    localparam logic REG_SEQ_LENGTH = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(7);

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POPLD,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/spc_pop_if.sv
// channel carrying popped values into the checker
`default_nettype none

interface spc_pop_if;
    import spc_pkg::*;

    logic   valid;
    logic   ready;
    value_t popped_value;

    modport source (output valid, output popped_value, input ready);
    modport sink (input valid, input popped_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spc_verdict_if.sv
// channel carrying one verdict per finished sequence
`default_nettype none

interface spc_verdict_if;
    logic valid;
    logic ready;
    logic sequence_valid;

    modport source (output valid, output sequence_valid, input ready);
    modport sink (input valid, input sequence_valid, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spc_ram.sv
// generic single write port ram with registered read
`default_nettype none

module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/stack_pop_sequence_checker.sv
// stack pop sequence checker top level: apb registers, sequencer and stack
//
// pop_in takes one popped value per transfer; verdict_out gives one
// sequence_valid transfer after each seq_length-th value of a sequence.
// the stack holds 1..n pushed in increasing order; the top entry lives in a
// register and the entries below it in a ram with one write and one read port.
// an item goes through check, doing each push that it causes in turn,
// then popld when a pop leaves the stack non-empty (ram read of the new
// top), then done; an item after its sequence has failed goes to done.
// the push sequencer does one push per cycle; over a sequence of
// n values at most n pushes happen in total.
// pop_in.ready is high only while the sequencer is idle.
// the verdict sits in an output register; if the receiver stalls, the next
// item is still taken and worked on, and the sequencer only waits when it
// must hand over a second verdict before the first is taken.
// reset clears the counters and the verdict valid bit, and sets stack_capacity
// to 5 and seq_length to 7; the stack ram needs no clearing.
// registers: stack_capacity at byte address 0, seq_length at 4; write only
// while no item is in progress.
`default_nettype none

module stack_pop_sequence_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    spc_pop_if.sink                               pop_in,
    spc_verdict_if.source                         verdict_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [spc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [spc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [spc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import spc_pkg::*;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [NPUSH_W-1:0]   npush_reg, npush_next;
    logic [LEN_W-1:0]     seen_reg, seen_next;
    logic                 failed_reg, failed_next;
    value_t               top_reg, top_next;
    value_t               value_reg, value_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_data_reg, out_data_next;

    logic [LEN_W-1:0]     len_eff;
    logic [COUNT_W-1:0]   cap_eff;
    logic                 cfg_write;
    logic                 top_match;
    logic                 can_push;
    logic                 need_result;
    logic                 push;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    value_t               ram_rdata;

    spc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_STACK_CAPACITY: prdata = APB_DATA_W'(cap_reg);
            REG_SEQ_LENGTH:     prdata = APB_DATA_W'(len_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            len_reg <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_STACK_CAPACITY: cap_reg <= pwdata[CAP_W-1:0];
                REG_SEQ_LENGTH:     len_reg <= pwdata[LEN_W-1:0];
                default:            cap_reg <= cap_reg;
            endcase
        end
    end

    assign len_eff = (len_reg == '0) ? LEN_W'(1) : len_reg;
    assign cap_eff = (CMP_W'(cap_reg) > CMP_W'(STACK_DEPTH)) ? COUNT_W'(STACK_DEPTH)
                                                              : COUNT_W'(cap_reg);

    assign top_match   = (count_reg != '0) && (top_reg == value_reg);
    assign can_push    = npush_reg <= NPUSH_W'(len_eff);
    assign need_result = (NPUSH_W'(seen_reg) + NPUSH_W'(1)) >= NPUSH_W'(len_eff);

    assign pop_in.ready          = (state_reg == ST_IDLE);
    assign verdict_out.valid     = out_valid_reg;
    assign verdict_out.sequence_valid = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            npush_reg     <= NPUSH_W'(1);
            seen_reg      <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            npush_reg     <= npush_next;
            seen_reg      <= seen_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        value_reg    <= value_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        npush_next     = npush_reg;
        seen_next      = seen_reg;
        failed_next    = failed_reg;
        top_next       = top_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && !verdict_out.ready;
        out_data_next  = out_data_reg;
        push           = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(count_reg - COUNT_W'(1));
        ram_raddr      = ADDR_W'(count_reg - COUNT_W'(2));

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_in.valid)
                begin
                    value_next = pop_in.popped_value;
                    state_next = failed_reg ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (top_match)
                begin
                    // pop; refill the top register from the ram when entries remain
                    count_next = count_reg - COUNT_W'(1);
                    state_next = (count_reg > COUNT_W'(1)) ? ST_POPLD : ST_DONE;
                end
                else if (!can_push || count_reg >= cap_eff)
                begin
                    failed_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    push       = 1'b1;
                    ram_we     = (count_reg != '0);
                    top_next   = VALUE_W'(npush_reg);
                    count_next = count_reg + COUNT_W'(1);
                    npush_next = npush_reg + NPUSH_W'(1);
                end
            end
            ST_POPLD:
            begin
                top_next   = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!need_result)
                begin
                    seen_next  = seen_reg + LEN_W'(1);
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || verdict_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = !failed_reg;
                    count_next     = '0;
                    npush_next     = NPUSH_W'(1);
                    seen_next      = '0;
                    failed_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stack never grows past the ram
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_W'(count_reg) <= COUNT_W'(STACK_DEPTH))
    else $error("stack count exceeds ram depth");

    // a push moves count and next value together
    a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == $past(count_reg) + COUNT_W'(1))
              && (npush_reg == $past(npush_reg) + NPUSH_W'(1)))
    else $error("push did not advance count and next value together");

    // a new verdict only comes from the done state and re-arms the sequence
    a_verdict_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && state_next == ST_IDLE && need_result)
        |=> out_valid_reg && count_reg == '0 && !failed_reg && seen_reg == '0)
    else $error("verdict transfer did not re-arm the checker");

endmodule

`default_nettype wire
